>>> rtl/drs_pkg.sv
// Shared types and constants for the disk request scheduler.
`default_nettype none

package drs_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned BlockBits  = 16;
  localparam int unsigned TagBits    = 8;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned TotalW     = 32;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  // register index of the policy register (byte address 4*index)
  localparam logic [ApbAddrW-3:0] RegPolicy = '0;

  typedef enum logic [0:0] {
    OP_ENQUEUE  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_CSCAN = 2'd2
  } policy_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                  operation;
    logic [BlockBits-1:0] block_number;
    logic                 is_write;
    logic [TagBits-1:0]   request_tag;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [BlockBits-1:0] chosen_block;
    logic                 chosen_write;
    logic [TagBits-1:0]   chosen_tag;
    logic [BlockBits-1:0] seek_distance;
    logic [TotalW-1:0]    total_seek;
    logic [CntW-1:0]      pending_count;
  } rsp_t;

  typedef struct packed {
    logic                 is_write;
    logic [TagBits-1:0]   tag;
    logic [BlockBits-1:0] block;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/disk_request_scheduler.sv
// Disk request scheduler: a queue of up to QueueDepth block requests kept in arrival order.
// An enqueue request is stored and answered with status enqueued or full.
// A dispatch request walks the queue with one subtractor and one comparator, one entry per
// cycle out of a queue memory with one write port and one registered read port: FCFS reads
// only the oldest entry, SSTF and C-SCAN read all N pending entries. The chosen entry is then
// removed by moving each younger entry down one slot, one per cycle (N - idx - 1 moves),
// after which the last served block and the saturating seek total are updated. The block
// takes one request at a time; the result sits in an output register, and the next request
// is taken as soon as the result has been written there.
// Policy is written through the APB port at byte address 0; code 3 acts as FCFS.
`default_nettype none

module disk_request_scheduler (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire drs_pkg::req_t                    in_req_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output drs_pkg::rsp_t                         out_rsp_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [drs_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [drs_pkg::ApbDataW-1:0]     pwdata,
  output logic [drs_pkg::ApbDataW-1:0]          prdata,
  output logic                                  pready
);
  import drs_pkg::*;

  // queue memory
  entry_t              mem_q [QueueDepth];
  entry_t              rd_data_q;
  logic [IdxW-1:0]     rd_addr;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  entry_t              wr_data;

  // control and state
  state_e              state_q, state_d;
  policy_e             policy_q;
  logic [CntW-1:0]     occ_q, occ_d;
  logic [BlockBits-1:0] last_q, last_d;
  logic [TotalW-1:0]   total_q, total_d;
  status_e             status_q, status_d;

  // scan / shift pointers
  logic [CntW-1:0]     scan_idx_q, scan_idx_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                cmp_vld_q, cmp_vld_d;

  // best candidate so far
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic [BlockBits:0]  best_key_q, best_key_d;
  logic [BlockBits-1:0] best_dist_q, best_dist_d;
  entry_t              best_ent_q, best_ent_d;

  // output register
  logic                out_valid_q, out_valid_d;
  rsp_t                out_rsp_q, out_rsp_d;

  // shared compare unit
  logic [BlockBits:0]   diff;
  logic                 below;
  logic [BlockBits-1:0] abs_dist;
  logic [BlockBits:0]   key;
  logic                 take;
  logic                 issue;
  logic [CntW-1:0]      limit;
  logic [TotalW:0]      sum;

  logic in_acc;
  logic cfg_wr;
  logic out_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ApbAddrW-1:2] == RegPolicy);
  assign prdata = {{(ApbDataW-2){1'b0}}, policy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FCFS;
    end else if (cfg_wr) begin
      policy_q <= policy_e'(pwdata[1:0]);
    end
  end

  // distance and ordering key of the entry coming out of memory
  assign diff     = {1'b0, rd_data_q.block} - {1'b0, last_q};
  assign below    = diff[BlockBits];
  assign abs_dist = below ? (~diff[BlockBits-1:0] + 1'b1) : diff[BlockBits-1:0];
  // C-SCAN ranks wrapped entries after those at or above the head
  assign key      = (policy_q == POL_CSCAN) ? {below, rd_data_q.block} : {1'b0, abs_dist};
  assign take     = (cmp_idx_q == '0) || (key < best_key_q);

  // FCFS (and the unused code) only looks at the oldest entry
  assign limit = ((policy_q == POL_SSTF) || (policy_q == POL_CSCAN)) ? occ_q : CntW'(1);
  assign issue = (state_q == S_SCAN) ? (scan_idx_q < limit) : (scan_idx_q < occ_q);

  assign sum = {1'b0, total_q} + {{(TotalW + 1 - BlockBits){1'b0}}, best_dist_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_i.operation == OP_DISPATCH && occ_q != '0) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (!issue) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!issue) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    occ_d       = occ_q;
    last_d      = last_q;
    total_d     = total_q;
    status_d    = status_q;
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    best_idx_d  = best_idx_q;
    best_key_d  = best_key_q;
    best_dist_d = best_dist_q;
    best_ent_d  = best_ent_q;
    rd_addr     = scan_idx_q[IdxW-1:0];
    wr_en       = 1'b0;
    wr_addr     = occ_q[IdxW-1:0];
    wr_data     = '{is_write: in_req_i.is_write, tag: in_req_i.request_tag,
                    block: in_req_i.block_number};
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          scan_idx_d = '0;
          if (in_req_i.operation == OP_ENQUEUE) begin
            if (occ_q == CntW'(QueueDepth)) begin
              status_d = ST_FULL;
            end else begin
              wr_en    = 1'b1;
              occ_d    = occ_q + 1'b1;
              status_d = ST_ENQUEUED;
            end
          end else if (occ_q == '0) begin
            status_d = ST_EMPTY;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_idx_d = scan_idx_q + 1'b1;
          cmp_idx_d  = scan_idx_q[IdxW-1:0];
          cmp_vld_d  = 1'b1;
        end
        if (cmp_vld_q && take) begin
          best_idx_d  = cmp_idx_q;
          best_key_d  = key;
          best_dist_d = abs_dist;
          best_ent_d  = rd_data_q;
        end
        if (!issue) begin
          // start moving the younger entries down over the chosen one
          scan_idx_d = CntW'(best_idx_d) + CntW'(1);
        end
      end
      S_SHIFT: begin
        if (issue) begin
          scan_idx_d = scan_idx_q + 1'b1;
          cmp_idx_d  = scan_idx_q[IdxW-1:0];
          cmp_vld_d  = 1'b1;
        end
        if (cmp_vld_q) begin
          wr_en   = 1'b1;
          wr_addr = cmp_idx_q - 1'b1;
          wr_data = rd_data_q;
        end
        if (!issue) begin
          occ_d    = occ_q - 1'b1;
          last_d   = best_ent_q.block;
          total_d  = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
          status_d = ST_DISPATCHED;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_rsp_d.status        = status_q;
          out_rsp_d.total_seek    = total_q;
          out_rsp_d.pending_count = occ_q;
          if (status_q == ST_DISPATCHED) begin
            out_rsp_d.chosen_block  = best_ent_q.block;
            out_rsp_d.chosen_write  = best_ent_q.is_write;
            out_rsp_d.chosen_tag    = best_ent_q.tag;
            out_rsp_d.seek_distance = best_dist_q;
          end else begin
            out_rsp_d.chosen_block  = '0;
            out_rsp_d.chosen_write  = 1'b0;
            out_rsp_d.chosen_tag    = '0;
            out_rsp_d.seek_distance = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // queue memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      last_q      <= '0;
      total_q     <= '0;
      status_q    <= ST_ENQUEUED;
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      last_q      <= last_d;
      total_q     <= total_d;
      status_q    <= status_d;
      scan_idx_q  <= scan_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_key_q  <= best_key_d;
    best_dist_q <= best_dist_d;
    best_ent_q  <= best_ent_d;
    out_rsp_q   <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

>>> bench/disk_request_scheduler_test.sv
// Self-checking bench for the disk request scheduler: queue, three policies, APB policy register.
module disk_request_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import drs_pkg::*;

  // APB map: the policy register at index RegPolicy, one unmapped word after it
  localparam logic [ApbAddrW-1:0] PolicyAddr = {RegPolicy, 2'b00};
  localparam logic [ApbAddrW-1:0] SpareAddr  = PolicyAddr + ApbAddrW'(4);

  // the policy code the package leaves unnamed; the block treats it as FCFS
  localparam logic [1:0] PolUnused = 2'd3;

  localparam int unsigned HoldOffCycles = 300;  // long receiver stall for the pressure test
  localparam int unsigned DrainCycles   = 40;   // quiet window after the last response

  // ---------------------------------------------------------------------------
  // clock, reset and DUT ports
  // ---------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  req_t                in_req    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rsp_t                out_rsp;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ApbAddrW-1:0] paddr     = '0;
  logic [ApbDataW-1:0] pwdata    = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  disk_request_scheduler u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // scheduler shadow: pending queue in arrival order (index 0 oldest),
  // head position, saturating seek total and the policy register
  // ---------------------------------------------------------------------------
  entry_t               queued[$];
  logic [BlockBits-1:0] head_block = '0;
  logic [TotalW-1:0]    seek_sum   = '0;
  logic [1:0]           policy_reg = POL_FCFS;

  rsp_t expected_outcomes[$];   // one entry per accepted request, oldest first

  // knobs shared between the stimulus tasks and the response checker
  int unsigned sender_gap_max   = 0;
  int unsigned receiver_gap_max = 0;
  int unsigned hold_off_cycles  = 0;

  // bookkeeping
  int unsigned error_count = 0;
  int unsigned n_queued    = 0;
  int unsigned n_served    = 0;
  int unsigned n_full      = 0;
  int unsigned n_empty     = 0;
  int unsigned served_by_policy [4] = '{0, 0, 0, 0};

  function automatic logic [BlockBits-1:0] seek_gap(input logic [BlockBits-1:0] a,
                                                   input logic [BlockBits-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Index of the entry the current policy serves next; queue is non-empty.
  function automatic int pick_victim();
    int                   best;
    int                   up;
    int                   low;
    bit                   found_up;
    logic [BlockBits-1:0] best_d;
    logic [BlockBits-1:0] d;
    case (policy_reg)
      POL_SSTF: begin
        // strict compare: the oldest of equally near entries wins
        best   = 0;
        best_d = seek_gap(queued[0].block, head_block);
        for (int i = 1; i < queued.size(); i++) begin
          d = seek_gap(queued[i].block, head_block);
          if (d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
        return best;
      end
      POL_CSCAN: begin
        // lowest block at or above the head; wrap to the lowest block if none
        low      = 0;
        up       = 0;
        found_up = 1'b0;
        for (int i = 0; i < queued.size(); i++) begin
          if (queued[i].block < queued[low].block) low = i;
          if (queued[i].block >= head_block &&
              (!found_up || queued[i].block < queued[up].block)) begin
            up       = i;
            found_up = 1'b1;
          end
        end
        return found_up ? up : low;
      end
      default: return 0;  // FCFS, and the unused code behaves the same
    endcase
  endfunction

  // Applies one accepted request to the shadow and returns its response.
  function automatic rsp_t schedule_request(input req_t r);
    rsp_t            o;
    int              idx;
    logic [TotalW:0] sum;
    o = '0;
    if (r.operation == OP_ENQUEUE) begin
      if (queued.size() >= QueueDepth) begin
        o.status = ST_FULL;
        n_full++;
      end else begin
        queued.push_back(entry_t'{is_write: r.is_write, tag: r.request_tag,
                                  block: r.block_number});
        o.status = ST_ENQUEUED;
        n_queued++;
      end
    end else if (queued.size() == 0) begin
      o.status = ST_EMPTY;
      n_empty++;
    end else begin
      idx             = pick_victim();
      o.status        = ST_DISPATCHED;
      o.chosen_block  = queued[idx].block;
      o.chosen_write  = queued[idx].is_write;
      o.chosen_tag    = queued[idx].tag;
      o.seek_distance = seek_gap(queued[idx].block, head_block);
      queued.delete(idx);
      head_block = o.chosen_block;
      sum        = {1'b0, seek_sum} + {{(TotalW + 1 - BlockBits){1'b0}}, o.seek_distance};
      seek_sum   = sum[TotalW] ? '1 : sum[TotalW-1:0];
      n_served++;
      served_by_policy[policy_reg]++;
    end
    o.total_seek    = seek_sum;
    o.pending_count = CntW'(queued.size());
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // request construction
  // ---------------------------------------------------------------------------
  function automatic req_t make_request(input op_e op, input logic [BlockBits-1:0] blk,
                                        input logic wr, input logic [TagBits-1:0] tag);
    req_t r;
    r.operation    = op;
    r.block_number = blk;
    r.is_write     = wr;
    r.request_tag  = tag;
    return r;
  endfunction

  // Blocks cluster near the head often enough to produce distance ties and
  // repeated blocks; some sit at either end or near 16'h4000; the rest spread over the whole range.
  function automatic logic [BlockBits-1:0] random_block();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? '1 : '0;
      1, 2:    return head_block + BlockBits'($urandom_range(0, 8) * 4) - BlockBits'(16);
      3:       return BlockBits'(16'h4000 + $urandom_range(0, 6) * 8);
      default: return BlockBits'($urandom);
    endcase
  endfunction

  function automatic req_t random_request(input bit enqueue);
    return make_request(enqueue ? OP_ENQUEUE : OP_DISPATCH, random_block(),
                        1'($urandom_range(0, 1)), TagBits'($urandom_range(0, 255)));
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: optional idle gap, then hold valid until the handshake.
  // valid stays high across back-to-back requests; it is lowered only when a
  // gap is drawn or the sender goes quiet in wait_drained.
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    expected_outcomes.push_back(schedule_request(r));
  endtask

  // Sender goes quiet until every outstanding response has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // APB: setup cycle, then access cycle; the write lands when pready is high
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [ApbAddrW-1:0] addr,
                                input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == PolicyAddr) policy_reg = data[1:0];
  endtask

  // bus idle after the preceding write, then a read
  task automatic check_policy_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PolicyAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== ApbDataW'(policy_reg)) begin
      error_count++;
      $display("%0t ns: policy readback mismatch, expected %0h, got %0h",
               $time, ApbDataW'(policy_reg), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_policy(input logic [ApbDataW-1:0] value);
    write_register(PolicyAddr, value);
    check_policy_readback();
  endtask

  // ---------------------------------------------------------------------------
  // response checker: random (or forced long) stall, then accept one response
  // and compare it field by field with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  initial begin : response_checker
    int unsigned stall;
    rsp_t        want;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles != 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, receiver_gap_max);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_outcomes.size() == 0) begin
        error_count++;
        $display("%0t ns: response with nothing outstanding, expected none, got %h",
                 $time, out_rsp);
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("status",        32'(want.status),        32'(out_rsp.status));
        compare_field("chosen_block",  32'(want.chosen_block),  32'(out_rsp.chosen_block));
        compare_field("chosen_write",  32'(want.chosen_write),  32'(out_rsp.chosen_write));
        compare_field("chosen_tag",    32'(want.chosen_tag),    32'(out_rsp.chosen_tag));
        compare_field("seek_distance", 32'(want.seek_distance), 32'(out_rsp.seek_distance));
        compare_field("total_seek",    32'(want.total_seek),    32'(out_rsp.total_seek));
        compare_field("pending_count", 32'(want.pending_count), 32'(out_rsp.pending_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // Empty dispatch, fill to the brim with extreme blocks and tags, overflow,
  // then walk every policy over the queue, including the C-SCAN wrap,
  // the unused policy code, an unmapped write and a write with high bits set.
  task automatic test_boundaries();
    logic [BlockBits-1:0] seed_blocks [16] = '{
      16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h1000, 16'h3000, 16'h5555, 16'hAAAA,
      16'h0001, 16'hFFFE, 16'h2000, 16'h1000, 16'h00FF, 16'hFF00, 16'h4000, 16'hC000};
    sender_gap_max   = 2;
    receiver_gap_max = 2;
    set_policy(ApbDataW'(POL_FCFS));
    send_request(random_request(1'b0));                 // nothing queued yet
    for (int i = 0; i < QueueDepth; i++)
      send_request(make_request(OP_ENQUEUE, seed_blocks[i], 1'(i), TagBits'(i * 17)));
    send_request(make_request(OP_ENQUEUE, 16'h1234, 1'b1, 8'hA5));  // queue full, dropped
    send_request(random_request(1'b0));                 // oldest, head jumps to the top
    wait_drained();
    set_policy(ApbDataW'(POL_SSTF));
    repeat (2) send_request(random_request(1'b0));      // nearest to the top end
    wait_drained();
    set_policy(ApbDataW'(POL_CSCAN));
    repeat (4) send_request(random_request(1'b0));      // nothing above: wrap to bottom
    wait_drained();
    set_policy(ApbDataW'(PolUnused));
    send_request(random_request(1'b0));
    wait_drained();
    write_register(SpareAddr, ApbDataW'(POL_SSTF));     // unmapped, must not move policy
    check_policy_readback();
    send_request(random_request(1'b0));
    wait_drained();
    set_policy(32'hFFFF_FFFD);                          // only the low two bits count
    send_request(random_request(1'b0));
    wait_drained();
  endtask

  // Bulk random traffic in phases; each phase picks a policy and idle profile.
  // Within a phase the mix swings between filling and draining so both the
  // full and the empty corners come up regularly.
  task automatic test_random_mix();
    logic [1:0]  plan_policy [7] = '{POL_SSTF, POL_CSCAN, POL_FCFS, PolUnused,
                                     POL_CSCAN, POL_SSTF, POL_CSCAN};
    int unsigned plan_items  [7] = '{300, 250, 200, 150, 300, 300, 150};
    int unsigned plan_send   [7] = '{8, 0, 8, 0, 8, 0, 4};
    int unsigned plan_recv   [7] = '{8, 0, 0, 8, 8, 0, 4};
    bit          filling;
    filling = 1'b1;
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      set_policy(ApbDataW'(plan_policy[p]));
      sender_gap_max   = plan_send[p];
      receiver_gap_max = plan_recv[p];
      for (int n = 0; n < plan_items[p]; n++) begin
        if (queued.size() == QueueDepth && $urandom_range(0, 2) == 0) filling = 1'b0;
        if (queued.size() == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
        send_request(random_request($urandom_range(0, 9) < (filling ? 8 : 2)));
      end
    end
    wait_drained();
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering
  // back-to-back requests, so the block backs up and holds off its input.
  task automatic test_backpressure();
    set_policy(ApbDataW'(POL_SSTF));
    sender_gap_max   = 0;
    receiver_gap_max = 2;
    hold_off_cycles  = HoldOffCycles;
    for (int n = 0; n < 60; n++)
      send_request(random_request(1'($urandom_range(0, 1))));
    wait_drained();
  endtask

  // Short bursts, each followed by the sender pausing until all responses are in.
  task automatic test_sender_pause();
    set_policy(ApbDataW'(POL_CSCAN));
    sender_gap_max   = 8;
    receiver_gap_max = 8;
    for (int round = 0; round < 6; round++) begin
      for (int n = 0; n < 8; n++)
        send_request(random_request($urandom_range(0, 9) < 6));
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_boundaries();
    test_random_mix();
    test_backpressure();
    test_sender_pause();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d requests: %0d queued, %0d served, %0d refused on a full queue, %0d on empty.",
             n_queued + n_served + n_full + n_empty, n_queued, n_served, n_full, n_empty);
    $display("Served under FCFS %0d, SSTF %0d, C-SCAN %0d, code 3 %0d; final seek total %0d.",
             served_by_policy[POL_FCFS], served_by_policy[POL_SSTF],
             served_by_policy[POL_CSCAN], served_by_policy[PolUnused], seek_sum);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
